/* rtl/quadtree_image_bitstream_decoder_core_defines.svh */
// Assertion macros used by the checker of the quadtree decoder.
`ifndef QUADTREE_IMAGE_BITSTREAM_DECODER_CORE_DEFINES_SVH
`define QUADTREE_IMAGE_BITSTREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QTD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qtd checker: implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define QTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qtd checker: next-cycle implication failed");

`endif

/* rtl/qtd_pkg.sv */
package qtd_pkg;

  // Tree geometry.
  localparam int unsigned MAX_DEPTH     = 6;
  localparam int unsigned NODE_CAPACITY = 5461;

  // Field widths.
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned LVL_W    = 3;
  localparam int unsigned MEAN_W   = 8;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BIDX_W   = 3;
  localparam int unsigned BITS_W   = 4;
  localparam int unsigned SUM_W    = 10;

  // Stream bus widths.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_PENDING  = 3'd3,
    ST_BEYOND   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_MEAN    = 2'd0,
    PH_ERROR   = 2'd1,
    PH_UNIFORM = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_SETTLE,
    S_PARENT,
    S_RDATA,
    S_RESP
  } state_e;

  // One stored node, mean in the upper bits.
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [ERR_W-1:0]  err;
    logic              uni;
  } node_t;

  // Node store access: one write and one read port.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // One result item.
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] nodes_done;
    node_t            node;
  } res_t;

  // Breadth-first index of the first node of a level.
  function automatic logic [IDX_W-1:0] level_start(input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] r;
    unique case (lvl)
      3'd0: r = 13'd0;
      3'd1: r = 13'd1;
      3'd2: r = 13'd5;
      3'd3: r = 13'd21;
      3'd4: r = 13'd85;
      3'd5: r = 13'd341;
      3'd6: r = 13'd1365;
      3'd7: r = 13'd5461;
    endcase
    return r;
  endfunction

endpackage

/* rtl/qtd_node_ram.sv */
module qtd_node_ram (
  input  logic               clk_i,
  input  qtd_pkg::mem_req_t  req_i,
  output qtd_pkg::node_t     rdata_o
);

  qtd_pkg::node_t mem [qtd_pkg::NODE_CAPACITY];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

/* rtl/qtd_ctrl.sv */
module qtd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  qtd_pkg::cmd_e                 in_cmd_i,
  input  logic [qtd_pkg::BYTE_W-1:0]    in_byte_i,
  input  logic [qtd_pkg::IDX_W-1:0]     in_index_i,
  input  logic                          cfg_we_i,
  input  logic [qtd_pkg::LVL_W-1:0]     cfg_wdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output qtd_pkg::res_t                 res_o,
  output qtd_pkg::mem_req_t             mem_req_o,
  input  qtd_pkg::node_t                mem_rdata_i
);

  qtd_pkg::state_e  state_q, state_d;
  qtd_pkg::phase_e  phase_q, phase_d;
  qtd_pkg::cmd_e    cmd_q, cmd_d;
  qtd_pkg::status_e status_q, status_d;
  qtd_pkg::node_t   node_q, node_d;

  logic [qtd_pkg::LVL_W-1:0]  depth_q, depth_d;
  logic [qtd_pkg::LVL_W-1:0]  level_q, level_d;
  logic [qtd_pkg::IDX_W-1:0]  pos_q, pos_d;
  logic [qtd_pkg::MEAN_W-1:0] acc_q, acc_d;
  logic [qtd_pkg::BITS_W-1:0] bits_q, bits_d;
  logic                       complete_q, complete_d;
  logic [qtd_pkg::MEAN_W-1:0] cur_mean_q, cur_mean_d;
  logic [qtd_pkg::ERR_W-1:0]  cur_err_q, cur_err_d;
  logic [qtd_pkg::SUM_W-1:0]  sib_sum_q, sib_sum_d;
  logic [qtd_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic [qtd_pkg::BIDX_W-1:0] bidx_q, bidx_d;
  logic                       last_q, last_d;

  logic [qtd_pkg::LVL_W-1:0]  eff_depth;
  logic [qtd_pkg::IDX_W-1:0]  limit_raw;
  logic [qtd_pkg::IDX_W-1:0]  node_limit;
  logic [qtd_pkg::IDX_W-1:0]  next_lvl_start;
  logic [qtd_pkg::IDX_W-1:0]  pos_inc;
  logic [qtd_pkg::IDX_W-1:0]  pos_dec;
  logic [qtd_pkg::IDX_W-1:0]  parent_addr;
  logic [qtd_pkg::MEAN_W-1:0] new_acc;
  logic [qtd_pkg::BITS_W-1:0] new_bits;
  logic [qtd_pkg::MEAN_W-1:0] fourth_mean;
  logic                       accept;
  logic                       settle_stop;
  logic                       at_leaf;
  logic                       fourth;
  logic                       read_ok;
  logic                       node_we;
  qtd_pkg::node_t             node_wd;

  // Effective depth and the number of nodes in the tree.
  assign eff_depth = (depth_q > qtd_pkg::LVL_W'(qtd_pkg::MAX_DEPTH))
                   ? qtd_pkg::LVL_W'(qtd_pkg::MAX_DEPTH) : depth_q;
  assign limit_raw = qtd_pkg::level_start(eff_depth + qtd_pkg::LVL_W'(1));
  assign node_limit = (limit_raw < qtd_pkg::IDX_W'(qtd_pkg::NODE_CAPACITY))
                    ? limit_raw : qtd_pkg::IDX_W'(qtd_pkg::NODE_CAPACITY);
  assign next_lvl_start = qtd_pkg::level_start(level_q + qtd_pkg::LVL_W'(1));

  // Position arithmetic; the parent of node p sits at (p - 1) / 4.
  assign pos_inc     = pos_q + qtd_pkg::IDX_W'(1);
  assign pos_dec     = pos_q - qtd_pkg::IDX_W'(1);
  assign parent_addr = {2'b00, pos_dec[qtd_pkg::IDX_W-1:2]};
  assign fourth      = (pos_q[1:0] == 2'b00);

  // Bit shifted into the field accumulator.
  assign new_acc  = {acc_q[qtd_pkg::MEAN_W-2:0], byte_q[bidx_q]};
  assign new_bits = bits_q + qtd_pkg::BITS_W'(1);

  // Fourth sibling: 4 * parent mean + parent error - sibling means, mod 256.
  assign fourth_mean = {mem_rdata_i.mean[qtd_pkg::MEAN_W-3:0], 2'b00}
                     + {{(qtd_pkg::MEAN_W-qtd_pkg::ERR_W){1'b0}}, mem_rdata_i.err}
                     - sib_sum_q[qtd_pkg::MEAN_W-1:0];

  assign accept      = in_valid_i && (state_q == qtd_pkg::S_IDLE);
  assign settle_stop = complete_q || (level_q == '0);
  assign at_leaf     = (level_q == eff_depth);
  assign read_ok     = (in_index_i < node_limit) && (in_index_i < pos_q);

  // Datapath: bit decoding, node completion and restart.
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    node_d     = node_q;
    depth_d    = depth_q;
    level_d    = level_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    bits_d     = bits_q;
    complete_d = complete_q;
    cur_mean_d = cur_mean_q;
    cur_err_d  = cur_err_q;
    sib_sum_d  = sib_sum_q;
    byte_d     = byte_q;
    bidx_d     = bidx_q;
    last_d     = last_q;
    node_we    = 1'b0;
    node_wd    = '0;

    unique case (state_q)
      qtd_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d  = in_cmd_i;
          byte_d = in_byte_i;
          bidx_d = qtd_pkg::BIDX_W'(qtd_pkg::BYTE_W - 1);
          node_d = '0;
          unique case (in_cmd_i)
            qtd_pkg::CMD_RESTART: begin
              status_d   = qtd_pkg::ST_OK;
              pos_d      = '0;
              level_d    = '0;
              phase_d    = qtd_pkg::PH_MEAN;
              acc_d      = '0;
              bits_d     = '0;
              complete_d = 1'b0;
            end
            qtd_pkg::CMD_BYTE: begin
              status_d = complete_q ? qtd_pkg::ST_IGNORED : qtd_pkg::ST_OK;
            end
            qtd_pkg::CMD_READ: begin
              if (in_index_i >= node_limit) begin
                status_d = qtd_pkg::ST_BEYOND;
              end else if (in_index_i >= pos_q) begin
                status_d = qtd_pkg::ST_PENDING;
              end else begin
                status_d = qtd_pkg::ST_OK;
              end
            end
            qtd_pkg::CMD_NOP: begin
              status_d = qtd_pkg::ST_OK;
            end
          endcase
        end
      end

      qtd_pkg::S_BIT: begin
        bidx_d   = bidx_q - qtd_pkg::BIDX_W'(1);
        last_d   = (bidx_q == '0);
        status_d = qtd_pkg::ST_OK;
        acc_d    = new_acc;
        bits_d   = new_bits;
        unique case (phase_q)
          qtd_pkg::PH_MEAN: begin
            if (new_bits == qtd_pkg::BITS_W'(qtd_pkg::MEAN_W)) begin
              if ((level_q != '0) && at_leaf) begin
                node_we = 1'b1;
                node_wd = '{mean: new_acc, err: '0, uni: 1'b0};
              end else begin
                cur_mean_d = new_acc;
                phase_d    = qtd_pkg::PH_ERROR;
                acc_d      = '0;
                bits_d     = '0;
              end
            end
          end
          qtd_pkg::PH_ERROR: begin
            if (new_bits == qtd_pkg::BITS_W'(qtd_pkg::ERR_W)) begin
              if (new_acc[qtd_pkg::ERR_W-1:0] == '0) begin
                cur_err_d = '0;
                phase_d   = qtd_pkg::PH_UNIFORM;
                acc_d     = '0;
                bits_d    = '0;
              end else begin
                node_we = 1'b1;
                node_wd = '{mean: cur_mean_q, err: new_acc[qtd_pkg::ERR_W-1:0], uni: 1'b0};
              end
            end
          end
          default: begin
            // Uniform flag: a single bit ends the node.
            node_we = 1'b1;
            node_wd = '{mean: cur_mean_q, err: cur_err_q, uni: new_acc[0]};
          end
        endcase
      end

      qtd_pkg::S_SETTLE: begin
        status_d = complete_q ? qtd_pkg::ST_COMPLETE : qtd_pkg::ST_OK;
      end

      qtd_pkg::S_PARENT: begin
        status_d = qtd_pkg::ST_OK;
        if (mem_rdata_i.uni) begin
          // Child of a uniform parent copies it and reads nothing.
          node_we = 1'b1;
          node_wd = '{mean: mem_rdata_i.mean, err: '0, uni: 1'b1};
        end else if (fourth) begin
          if (at_leaf) begin
            node_we = 1'b1;
            node_wd = '{mean: fourth_mean, err: '0, uni: 1'b0};
          end else begin
            cur_mean_d = fourth_mean;
            phase_d    = qtd_pkg::PH_ERROR;
          end
        end
      end

      qtd_pkg::S_RDATA: begin
        node_d = mem_rdata_i;
      end

      qtd_pkg::S_RESP: begin
      end

      default: begin
      end
    endcase

    // A finished node moves the decode position on.
    if (node_we) begin
      pos_d   = pos_inc;
      phase_d = qtd_pkg::PH_MEAN;
      acc_d   = '0;
      bits_d  = '0;
      if (pos_q[1:0] == 2'b01) begin
        sib_sum_d = {{(qtd_pkg::SUM_W-qtd_pkg::MEAN_W){1'b0}}, node_wd.mean};
      end else begin
        sib_sum_d = sib_sum_q + {{(qtd_pkg::SUM_W-qtd_pkg::MEAN_W){1'b0}}, node_wd.mean};
      end
      if (pos_inc >= node_limit) begin
        complete_d = 1'b1;
      end else if (pos_inc >= next_lvl_start) begin
        level_d = level_q + qtd_pkg::LVL_W'(1);
      end
    end

    // A depth write restarts decoding.
    if (cfg_we_i) begin
      depth_d    = cfg_wdata_i;
      pos_d      = '0;
      level_d    = '0;
      phase_d    = qtd_pkg::PH_MEAN;
      acc_d      = '0;
      bits_d     = '0;
      complete_d = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qtd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            qtd_pkg::CMD_BYTE: state_d = complete_q ? qtd_pkg::S_RESP : qtd_pkg::S_BIT;
            qtd_pkg::CMD_READ: state_d = read_ok ? qtd_pkg::S_RDATA : qtd_pkg::S_RESP;
            qtd_pkg::CMD_RESTART,
            qtd_pkg::CMD_NOP:  state_d = qtd_pkg::S_RESP;
          endcase
        end
      end
      qtd_pkg::S_BIT: begin
        if (node_we) begin
          state_d = qtd_pkg::S_SETTLE;
        end else if (bidx_q == '0) begin
          state_d = qtd_pkg::S_RESP;
        end
      end
      qtd_pkg::S_SETTLE: begin
        if (!settle_stop) begin
          state_d = qtd_pkg::S_PARENT;
        end else if (complete_q || last_q) begin
          state_d = qtd_pkg::S_RESP;
        end else begin
          state_d = qtd_pkg::S_BIT;
        end
      end
      qtd_pkg::S_PARENT: begin
        if (node_we) begin
          state_d = qtd_pkg::S_SETTLE;
        end else if (last_q) begin
          state_d = qtd_pkg::S_RESP;
        end else begin
          state_d = qtd_pkg::S_BIT;
        end
      end
      qtd_pkg::S_RDATA: state_d = qtd_pkg::S_RESP;
      qtd_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = qtd_pkg::S_IDLE;
        end
      end
      default: state_d = qtd_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshakes, result and node store requests.
  always_comb begin
    in_ready_o         = (state_q == qtd_pkg::S_IDLE);
    res_valid_o        = (state_q == qtd_pkg::S_RESP);
    res_o.status       = status_q;
    res_o.nodes_done   = pos_q;
    res_o.node         = node_q;
    mem_req_o.we       = node_we;
    mem_req_o.waddr    = pos_q;
    mem_req_o.wdata    = node_wd;
    mem_req_o.re       = 1'b0;
    mem_req_o.raddr    = in_index_i;
    if (accept && (in_cmd_i == qtd_pkg::CMD_READ) && read_ok) begin
      mem_req_o.re = 1'b1;
    end else if ((state_q == qtd_pkg::S_SETTLE) && !settle_stop) begin
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = parent_addr;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= qtd_pkg::S_IDLE;
      phase_q    <= qtd_pkg::PH_MEAN;
      depth_q    <= '0;
      level_q    <= '0;
      pos_q      <= '0;
      acc_q      <= '0;
      bits_q     <= '0;
      complete_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      depth_q    <= depth_d;
      level_q    <= level_d;
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      bits_q     <= bits_d;
      complete_q <= complete_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    status_q   <= status_d;
    node_q     <= node_d;
    cur_mean_q <= cur_mean_d;
    cur_err_q  <= cur_err_d;
    sib_sum_q  <= sib_sum_d;
    byte_q     <= byte_d;
    bidx_q     <= bidx_d;
    last_q     <= last_d;
  end

endmodule

/* rtl/quadtree_image_bitstream_decoder_core.sv */
// Byte item: bits are taken one per cycle in S_BIT, held while each node finished within
// it (read, copied from a uniform parent or derived as a fourth sibling) passes S_SETTLE
// and, below the root, S_PARENT; the node that completes the tree cuts the byte short.
// Reads that find their node pass S_RDATA; other reads, restart, no-op, ignored bytes don't.
// One item at a time; the next is taken while the result waits in the output register.
// Reset zeroes decode state and depth; the store is not cleared (undecoded nodes: pending).
module quadtree_image_bitstream_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // stream_byte [7:0], node_index [20:8], zero [23:21]
  input  logic [qtd_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // command [1:0]
  input  logic [qtd_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // nodes_done [12:0], node_mean [20:13], node_error [22:21], node_uniform [23]
  output logic [qtd_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // status [2:0]
  output logic [qtd_pkg::STATUS_W-1:0]      m_axis_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [qtd_pkg::LVL_W-1:0]         cfg_wdata_i
);

  qtd_pkg::mem_req_t mem_req;
  qtd_pkg::node_t    mem_rdata;
  qtd_pkg::res_t     res, out_res_q;
  logic              res_valid, res_ready;
  logic              out_valid_q;

  qtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (qtd_pkg::cmd_e'(s_axis_tuser_i)),
    .in_byte_i   (s_axis_tdata_i[qtd_pkg::BYTE_W-1:0]),
    .in_index_i  (s_axis_tdata_i[qtd_pkg::BYTE_W +: qtd_pkg::IDX_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  qtd_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.node.uni, out_res_q.node.err,
                            out_res_q.node.mean, out_res_q.nodes_done};
  assign m_axis_tuser_o  = out_res_q.status;

endmodule

/* rtl/qtd_checker.sv */
`include "quadtree_image_bitstream_decoder_core_defines.svh"

module qtd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [qtd_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [qtd_pkg::STATUS_W-1:0]  m_axis_tuser_o
);

  // A stalled result item holds still.
  `QTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // Node fields are zero unless a read succeeded.
  `QTD_ASSERT_IMPLY(a_node_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != qtd_pkg::ST_OK), m_axis_tdata_o[23:13] == 11'd0)

  // The decoded count never passes the store size.
  `QTD_ASSERT_IMPLY(a_done_bound, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[12:0] <= 13'(qtd_pkg::NODE_CAPACITY))

  // A complete tree, and a byte ignored after it, has at least the root decoded.
  `QTD_ASSERT_IMPLY(a_complete_count, clk_i, rst_ni, m_axis_tvalid_o && ((m_axis_tuser_o == qtd_pkg::ST_COMPLETE) || (m_axis_tuser_o == qtd_pkg::ST_IGNORED)), m_axis_tdata_o[12:0] != 13'd0)

endmodule

bind quadtree_image_bitstream_decoder_core qtd_checker u_qtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import qtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned TARGET_ITEMS = 1250;
  localparam int unsigned QUIET_FROM   = 1120;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned ROW_COUNT    = 30;

  // One row of the directed table: either a depth write or an item.
  typedef struct packed {
    logic              cfg;
    logic [LVL_W-1:0]  depth;
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              fixed;
    status_e           st;
    logic [IDX_W-1:0]  nd;
    logic [MEAN_W-1:0] mean;
    logic [ERR_W-1:0]  er;
    logic              un;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   s_valid   = 1'b0;
  logic [S_TDATA_W-1:0]   s_data    = '0;
  logic [CMD_W-1:0]       s_user    = '0;
  logic                   m_ready   = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [LVL_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  // Decoder shadow state.
  node_t                  qt_store [NODE_CAPACITY];
  int unsigned            qt_pos;
  int unsigned            qt_lvl;
  phase_e                 qt_phase;
  int unsigned            qt_acc;
  int unsigned            qt_bits;
  bit                     qt_done;
  logic [LVL_W-1:0]       qt_depth;

  res_t                   awaited_results [$];
  bit                     idle_on  = 1'b0;
  bit                     hold_req = 1'b0;
  int unsigned            cycle_count    = 0;
  int unsigned            items_counted  = 0;
  int unsigned            results_seen   = 0;
  int unsigned            mismatch_count = 0;
  int unsigned            trees_done     = 0;
  int unsigned            depth_writes   = 0;

  dir_row_t directed_rows [ROW_COUNT] = '{
    // Fresh after reset at depth zero: pending, beyond, no-op.
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd0,    1'b1, ST_PENDING,  13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'h1FFF, 1'b1, ST_BEYOND,   13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_NOP,     8'hFF, 13'h1FFF, 1'b1, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    // Root alone: mean, then a partial node read, then error zero and uniform.
    '{1'b0, 3'd0, CMD_BYTE,    8'hFF, 13'd0,    1'b1, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd0,    1'b1, ST_PENDING,  13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h3F, 13'd0,    1'b1, ST_COMPLETE, 13'd1,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h00, 13'd0,    1'b1, ST_IGNORED,  13'd1,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd0,    1'b1, ST_OK,       13'd1,    8'hFF, 2'd0, 1'b1},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd1,    1'b1, ST_BEYOND,   13'd1,    8'h00, 2'd0, 1'b0},
    // Restart, then a root with the largest error.
    '{1'b0, 3'd0, CMD_RESTART, 8'h00, 13'd0,    1'b1, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h00, 13'd0,    1'b1, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'hC0, 13'd0,    1'b1, ST_COMPLETE, 13'd1,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd0,    1'b1, ST_OK,       13'd1,    8'h00, 2'd3, 1'b0},
    // Depth above the maximum, uniform root fills the whole tree.
    '{1'b1, 3'd7, CMD_NOP,     8'h00, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h80, 13'd0,    1'b1, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h20, 13'd0,    1'b1, ST_COMPLETE, 13'd5461, 8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd5460, 1'b1, ST_OK,       13'd5461, 8'h80, 2'd0, 1'b1},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd5461, 1'b1, ST_BEYOND,   13'd5461, 8'h00, 2'd0, 1'b0},
    // One level: three leaves read, the fourth derived from its parent.
    '{1'b1, 3'd1, CMD_NOP,     8'h00, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h40, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h47, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h10, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'h20, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'hF0, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd4,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    // Two levels with all-ones bytes: nonzero errors at every inner node decoded.
    '{1'b1, 3'd2, CMD_NOP,     8'h00, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'hFF, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'hFF, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_BYTE,    8'hFF, 13'd0,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0},
    '{1'b0, 3'd0, CMD_READ,    8'h00, 13'd1,    1'b0, ST_OK,       13'd0,    8'h00, 2'd0, 1'b0}
  };

  quadtree_image_bitstream_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Depth in use: anything above the maximum acts as the maximum.
  function automatic int unsigned deepest();
    return (qt_depth > MAX_DEPTH) ? MAX_DEPTH : int'(qt_depth);
  endfunction

  function automatic int unsigned level_base(input int unsigned lvl);
    return ((1 << (2 * lvl)) - 1) / 3;
  endfunction

  function automatic int unsigned tree_nodes();
    int unsigned total;
    total = level_base(deepest() + 1);
    return (total < NODE_CAPACITY) ? total : NODE_CAPACITY;
  endfunction

  function automatic void restart_decode();
    qt_pos   = 0;
    qt_lvl   = 0;
    qt_phase = PH_MEAN;
    qt_acc   = 0;
    qt_bits  = 0;
    qt_done  = 1'b0;
  endfunction

  function automatic void store_node(input int unsigned m, input int unsigned e,
                                     input int unsigned u);
    if (qt_pos < NODE_CAPACITY) begin
      qt_store[qt_pos] = '{mean: 8'(m), err: 2'(e), uni: 1'(u)};
    end
  endfunction

  // Move on to the next node in breadth-first order.
  function automatic void next_node();
    qt_pos++;
    qt_phase = PH_MEAN;
    qt_acc   = 0;
    qt_bits  = 0;
    if (qt_pos >= tree_nodes()) begin
      qt_done = 1'b1;
    end else if (qt_pos >= level_base(qt_lvl + 1)) begin
      qt_lvl++;
    end
  endfunction

  // Nodes under a uniform parent and derived fourth-sibling means take no bits.
  function automatic void fill_free_nodes();
    node_t       parent;
    int unsigned p;
    int unsigned m;
    while (!qt_done && qt_lvl > 0) begin
      p = qt_pos;
      parent = qt_store[(p - 1) / 4];
      if (parent.uni) begin
        store_node(parent.mean, 0, 1);
        next_node();
        continue;
      end
      if ((p & 3) == 0) begin
        m = 4 * int'(parent.mean) + int'(parent.err)
            - (int'(qt_store[p - 3].mean) + int'(qt_store[p - 2].mean)
               + int'(qt_store[p - 1].mean));
        m = m & 8'hFF;
        store_node(m, 0, 0);
        if (qt_lvl == deepest()) begin
          next_node();
          continue;
        end
        qt_phase = PH_ERROR;
      end
      break;
    end
  endfunction

  // Take one stream bit into the field being read.
  function automatic void shift_bit(input logic b);
    node_t cur;
    qt_acc = ((qt_acc << 1) | b) & 8'hFF;
    qt_bits++;
    cur = qt_store[qt_pos];
    case (qt_phase)
      PH_MEAN: begin
        if (qt_bits < 8) return;
        store_node(qt_acc, 0, 0);
        if (qt_lvl > 0 && qt_lvl == deepest()) begin
          next_node();
          fill_free_nodes();
          return;
        end
        qt_phase = PH_ERROR;
        qt_acc   = 0;
        qt_bits  = 0;
      end
      PH_ERROR: begin
        if (qt_bits < 2) return;
        store_node(cur.mean, qt_acc, 0);
        if (qt_acc == 0) begin
          qt_phase = PH_UNIFORM;
          qt_acc   = 0;
          qt_bits  = 0;
          return;
        end
        next_node();
        fill_free_nodes();
      end
      default: begin
        store_node(cur.mean, 0, qt_acc & 1);
        next_node();
        fill_free_nodes();
      end
    endcase
  endfunction

  // Expected result of one item; updates the shadow state.
  function automatic res_t decode_item(input cmd_e cmd, input logic [BYTE_W-1:0] b,
                                       input logic [IDX_W-1:0] idx);
    res_t r;
    int   i;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_RESTART: restart_decode();
      CMD_BYTE: begin
        if (qt_done) begin
          r.status = ST_IGNORED;
        end else begin
          for (i = 7; i >= 0 && !qt_done; i--) shift_bit(b[i]);
          r.status = qt_done ? ST_COMPLETE : ST_OK;
        end
      end
      CMD_READ: begin
        if (idx >= tree_nodes()) begin
          r.status = ST_BEYOND;
        end else if (idx >= qt_pos) begin
          r.status = ST_PENDING;
        end else begin
          r.node = qt_store[idx];
        end
      end
      default: ;
    endcase
    r.nodes_done = 13'(qt_pos);
    return r;
  endfunction

  // Offer one item, wait for its acceptance and queue its expected result.
  task automatic send_item(input cmd_e cmd, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] idx, input bit use_fixed,
                           input res_t fixed_res);
    res_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, idx, b};
    s_user  <= cmd;
    do @(posedge clk); while (!s_axis_tready_o);
    want = decode_item(cmd, b, idx);
    if (want.status != ST_IGNORED) items_counted++;
    if (want.status == ST_COMPLETE) trees_done++;
    if (use_fixed) want = fixed_res;
    awaited_results.push_back(want);
  endtask

  // Depth writes happen only once every result is back, so the block is idle.
  task automatic write_depth(input logic [LVL_W-1:0] d);
    s_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    qt_depth = d;
    restart_decode();
    depth_writes++;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t              want;
    logic [IDX_W-1:0]  got_nodes;
    logic [MEAN_W-1:0] got_mean;
    logic [ERR_W-1:0]  got_err;
    logic              got_uni;
    got_nodes = m_axis_tdata_o[12:0];
    got_mean  = m_axis_tdata_o[20:13];
    got_err   = m_axis_tdata_o[22:21];
    got_uni   = m_axis_tdata_o[23];
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result with no item waiting: status %0d nodes %0d",
                   m_axis_tuser_o, got_nodes);
        end
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser_o !== want.status || got_nodes !== want.nodes_done ||
            got_mean !== want.node.mean || got_err !== want.node.err ||
            got_uni !== want.node.uni) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result %0d: expected status %0d nodes %0d mean %0h",
                     results_seen, want.status, want.nodes_done, want.node.mean,
                     " err %0d uni %0d", want.node.err, want.node.uni);
            $display("  got status %0d nodes %0d mean %0h err %0d uni %0d",
                     m_axis_tuser_o, got_nodes, got_mean, got_err, got_uni);
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d results outstanding", awaited_results.size());
    $display("** quadtree_image_bitstream_decoder_core: FAILED **");
    $finish;
  end

  initial begin
    int unsigned       d;
    int unsigned       n;
    int unsigned       k;
    int unsigned       sel;
    int unsigned       r;
    bit                hold_done;
    cmd_e              cmd;
    logic [BYTE_W-1:0] b;
    logic [IDX_W-1:0]  idx;
    res_t              row_res;
    hold_done = 1'b0;
    for (int i = 0; i < NODE_CAPACITY; i++) qt_store[i] = '0;
    qt_depth = '0;
    restart_decode();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    idle_on = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        write_depth(directed_rows[i].depth);
      end else begin
        row_res.status     = directed_rows[i].st;
        row_res.nodes_done = directed_rows[i].nd;
        row_res.node       = '{mean: directed_rows[i].mean, err: directed_rows[i].er,
                               uni: directed_rows[i].un};
        send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].idx,
                  directed_rows[i].fixed, row_res);
      end
    end

    // Random phases: one depth each, mostly stream bytes with reads mixed in, mostly reads once the tree is complete.
    while (items_counted < TARGET_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 16) d = $urandom_range(0, 3);
      else if (r < 18) d = 4;
      else if (r == 18) d = 5;
      else d = $urandom_range(6, 7);
      write_depth(3'(d));
      idle_on = (items_counted < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (!hold_done && items_counted > 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      n = (d <= 3) ? $urandom_range(20, 120) : $urandom_range(40, 150);
      for (k = 0; k < n && items_counted < TARGET_ITEMS; k++) begin
        if (items_counted >= QUIET_FROM) idle_on = 1'b0;
        sel = $urandom_range(0, 99);
        if (qt_done) begin
          if (sel < 15) cmd = CMD_BYTE;
          else if (sel < 70) cmd = CMD_READ;
          else if (sel < 85) cmd = CMD_RESTART;
          else cmd = CMD_NOP;
        end else begin
          if (sel < 72) cmd = CMD_BYTE;
          else if (sel < 92) cmd = CMD_READ;
          else if (sel < 96) cmd = CMD_RESTART;
          else cmd = CMD_NOP;
        end
        r = $urandom_range(0, 9);
        if (r == 0) b = 8'h00;
        else if (r == 1) b = 8'hFF;
        else b = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) idx = 13'($urandom);
        else if (r < 6 && qt_pos > 0) idx = 13'($urandom_range(0, qt_pos - 1));
        else idx = 13'($urandom_range(0, tree_nodes() - 1));
        send_item(cmd, b, idx, 1'b0, '0);
      end
    end

    // Drain and report.
    s_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d counted items over %0d depth writes.",
             results_seen, items_counted, depth_writes);
    $display("%0d trees decoded to completion; %0d mismatches.", trees_done,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("** quadtree_image_bitstream_decoder_core: PASSED **");
    end else begin
      $display("** quadtree_image_bitstream_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
